// ===== rtl/mpem_pkg.sv =====
// mpem_pkg: shared types, codes and sizing constants for the response matcher.
// No dependencies; used by every module under rtl/.

package mpem_pkg;

   localparam int PATTERN_BYTES        = 8;
   localparam int PATTERN_WIDTH        = 8 * PATTERN_BYTES;
   localparam int MAX_PATTERN_LEN      = 8;
   localparam int MAX_PATTERNS         = 4;
   localparam int NUM_PATTERNS_DEFAULT = 4;
   localparam int LEN_WIDTH            = 4;
   localparam int LENGTHS_WIDTH        = LEN_WIDTH * MAX_PATTERNS;
   localparam int COUNT_WIDTH          = 3;
   localparam int CSR_INDEX_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH       = PATTERN_WIDTH;
   localparam int MATCH_INDEX_WIDTH    = 2;

   localparam logic [7:0] ZERO_BYTE = 8'h00;

   typedef logic [LEN_WIDTH-1:0] progress_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PATTERN_A = 3'd0,
      REG_PATTERN_B = 3'd1,
      REG_PATTERN_C = 3'd2,
      REG_PATTERN_D = 3'd3,
      REG_LENGTHS   = 3'd4,
      REG_COUNT     = 3'd5,
      REG_TEXT_MODE = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BYTE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_IDLE   = 2'd0,
      STATUS_SEARCH = 2'd1,
      STATUS_MATCH  = 2'd2
   } status_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      status_type                   status;
      logic [MATCH_INDEX_WIDTH-1:0] match_index;
   } result_type;

   typedef struct packed {
      logic [LENGTHS_WIDTH-1:0] lengths;
      logic [COUNT_WIDTH-1:0]   count;
      logic                     text_mode;
   } ctrl_type;

endpackage

// ===== rtl/mpem_csr.sv =====
// mpem_csr: configuration registers (patterns, lengths, count, text mode).
// Depends on mpem_pkg.

module mpem_csr #(
   parameter int NUM_PATTERNS = mpem_pkg::NUM_PATTERNS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [mpem_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mpem_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output logic [NUM_PATTERNS-1:0][mpem_pkg::PATTERN_WIDTH-1:0] patterns,
   output mpem_pkg::ctrl_type                    ctrl
);

   logic [NUM_PATTERNS-1:0][mpem_pkg::PATTERN_WIDTH-1:0] pattern_ff, pattern_in;
   mpem_pkg::ctrl_type ctrl_ff, ctrl_in;

   always_comb begin
      pattern_in = pattern_ff;
      ctrl_in    = ctrl_ff;
      if (csr_write) begin
         // pattern slots beyond NUM_PATTERNS are never read, so not stored
         for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (csr_index < mpem_pkg::REG_LENGTHS &&
                csr_index[1:0] == 2'(i)) begin
               pattern_in[i] = csr_data;
            end
         end
         case (csr_index)
            mpem_pkg::REG_LENGTHS: begin
               ctrl_in.lengths = csr_data[mpem_pkg::LENGTHS_WIDTH-1:0];
            end
            mpem_pkg::REG_COUNT: begin
               ctrl_in.count = csr_data[mpem_pkg::COUNT_WIDTH-1:0];
            end
            mpem_pkg::REG_TEXT_MODE: begin
               ctrl_in.text_mode = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         ctrl_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         ctrl_ff    <= ctrl_in;
      end
   end

   assign patterns = pattern_ff;
   assign ctrl     = ctrl_ff;

endmodule

// ===== rtl/mpem_core.sv =====
// mpem_core: per-pattern progress counters, byte comparators and priority pick.
// Depends on mpem_pkg.

module mpem_core #(
   parameter int NUM_PATTERNS = mpem_pkg::NUM_PATTERNS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  mpem_pkg::item_type    item,
   input  logic [NUM_PATTERNS-1:0][mpem_pkg::PATTERN_WIDTH-1:0] patterns,
   input  mpem_pkg::ctrl_type    ctrl,
   output mpem_pkg::result_type  result
);

   mpem_pkg::progress_type progress_ff [NUM_PATTERNS];
   mpem_pkg::progress_type progress_in [NUM_PATTERNS];
   mpem_pkg::progress_type step_prog   [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] step_done;
   logic [NUM_PATTERNS-1:0] in_use;
   logic                    armed_ff, armed_in;
   logic [mpem_pkg::COUNT_WIDTH-1:0] used_count;

   assign used_count = (ctrl.count > mpem_pkg::COUNT_WIDTH'(NUM_PATTERNS)) ?
                       mpem_pkg::COUNT_WIDTH'(NUM_PATTERNS) : ctrl.count;

   // independent per-pattern compare and advance
   always_comb begin
      logic [mpem_pkg::LEN_WIDTH-1:0] len;
      logic [7:0]                     pbyte;
      logic                           hit;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         len = ctrl.lengths[i*mpem_pkg::LEN_WIDTH +: mpem_pkg::LEN_WIDTH];
         if (len > mpem_pkg::LEN_WIDTH'(mpem_pkg::MAX_PATTERN_LEN)) begin
            len = mpem_pkg::LEN_WIDTH'(mpem_pkg::MAX_PATTERN_LEN);
         end
         pbyte = patterns[i][{progress_ff[i][2:0], 3'b000} +: 8];
         hit   = (progress_ff[i] < mpem_pkg::LEN_WIDTH'(mpem_pkg::PATTERN_BYTES)) &&
                 (pbyte == item.rx_byte);
         // naive restart: a miss goes to zero without retrying byte zero
         step_prog[i] = hit ? progress_ff[i] + 1'b1 : '0;
         in_use[i]    = mpem_pkg::COUNT_WIDTH'(i) < used_count;
         step_done[i] = step_prog[i] >= len;
      end
   end

   // priority walk: first completed pattern ends the session
   always_comb begin
      logic blocked;
      blocked     = 1'b0;
      progress_in = progress_ff;
      armed_in    = armed_ff;
      result      = '{status: mpem_pkg::STATUS_IDLE, match_index: '0};
      if (fire) begin
         if (item.command == mpem_pkg::CMD_START) begin
            for (int i = 0; i < NUM_PATTERNS; i++) begin
               progress_in[i] = '0;
            end
            armed_in = 1'b1;
         end else if (armed_ff) begin
            result.status = mpem_pkg::STATUS_SEARCH;
            if (ctrl.text_mode && item.rx_byte == mpem_pkg::ZERO_BYTE) begin
               for (int i = 0; i < NUM_PATTERNS; i++) begin
                  if (in_use[i]) begin
                     progress_in[i] = '0;
                  end
               end
            end else begin
               for (int i = 0; i < NUM_PATTERNS; i++) begin
                  if (in_use[i] && !blocked) begin
                     progress_in[i] = step_prog[i];
                     if (step_done[i]) begin
                        blocked            = 1'b1;
                        armed_in           = 1'b0;
                        result.status      = mpem_pkg::STATUS_MATCH;
                        result.match_index = mpem_pkg::MATCH_INDEX_WIDTH'(i);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         for (int i = 0; i < NUM_PATTERNS; i++) begin
            progress_ff[i] <= '0;
         end
      end else begin
         armed_ff    <= armed_in;
         progress_ff <= progress_in;
      end
   end

`ifndef SYNTHESIS
   a_match_disarms: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == mpem_pkg::STATUS_MATCH |=> !armed_ff)
      else $error("session still armed after a match");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == mpem_pkg::CMD_START |=> armed_ff && progress_ff[0] == '0)
      else $error("start request did not arm and clear");

   a_progress_bound: assert property (@(posedge clock) disable iff (reset)
      progress_ff[0] <= mpem_pkg::LEN_WIDTH'(mpem_pkg::PATTERN_BYTES))
      else $error("progress count beyond pattern size");

   a_idle_when_unarmed: assert property (@(posedge clock) disable iff (reset)
      fire && !armed_ff |-> result.status == mpem_pkg::STATUS_IDLE)
      else $error("result reported while no session armed");
`endif

endmodule

// ===== rtl/multi_pattern_expect_matcher_top.sv =====
// An accepted request lands in the input register, then matcher logic feeds the response
// register once it is free or taken. Throughput: one request per cycle while rsp_stall is
// low; the compare and priority pick are combinational.
// Reset (synchronous, active high): registers zero, counts zero, no session armed, both
// pipeline stages empty.
// Depends on mpem_pkg, mpem_csr and mpem_core.

module multi_pattern_expect_matcher_top #(
   parameter int NUM_PATTERNS = mpem_pkg::NUM_PATTERNS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [7:0]                           req_rx_byte,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [mpem_pkg::MATCH_INDEX_WIDTH-1:0] rsp_match_index,
   // configuration
   input  logic                                 csr_write,
   input  logic [mpem_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mpem_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [NUM_PATTERNS-1:0][mpem_pkg::PATTERN_WIDTH-1:0] patterns;
   mpem_pkg::ctrl_type   ctrl;
   mpem_pkg::item_type   item_ff, item_in;
   mpem_pkg::result_type result;
   mpem_pkg::result_type result_ff, result_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;   // stage one may move into the response register
   logic fire;      // stage one request is processed this cycle
   logic req_accept;

   mpem_csr #(.NUM_PATTERNS(NUM_PATTERNS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .patterns  (patterns),
      .ctrl      (ctrl)
   );

   mpem_core #(.NUM_PATTERNS(NUM_PATTERNS)) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item_ff),
      .patterns (patterns),
      .ctrl     (ctrl),
      .result   (result)
   );

   // Response register empties or is taken: stage one can advance.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && advance;
   // Stage one is free or drains this cycle, so a new request can land.
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.command = req_command;
         item_in.rx_byte = req_rx_byte;
      end
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      result_in    = fire ? result : result_ff;
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = result_ff.status;
   assign rsp_match_index = result_ff.match_index;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with stage one empty");

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request produced no response");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(result_ff))
      else $error("stalled response lost or changed");
`endif

endmodule

// ===== dv/tb_multi_pattern_expect_matcher_top.sv =====
// Testbench for multi_pattern_expect_matcher_top: directed and random requests,
// with responses checked against an in-bench model of the matcher.
// Depends on mpem_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_multi_pattern_expect_matcher_top;

   localparam int LIMIT_CYCLES = 200000;
   // csr index past the register list; the block must ignore writes to it
   localparam logic [mpem_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

   // Tracks matcher state and configuration; holds the responses still owed.
   class match_scoreboard;
      logic [mpem_pkg::PATTERN_WIDTH-1:0] patterns [mpem_pkg::MAX_PATTERNS];
      logic [mpem_pkg::LENGTHS_WIDTH-1:0] lengths;
      logic [mpem_pkg::COUNT_WIDTH-1:0]   count;
      logic                               text_mode;
      mpem_pkg::progress_type             progress [mpem_pkg::MAX_PATTERNS];
      bit                                 session_armed;
      mpem_pkg::result_type               awaited [$];
      int                                 errors;

      function new();
         foreach (patterns[i]) begin
            patterns[i] = '0;
            progress[i] = '0;
         end
         lengths       = '0;
         count         = '0;
         text_mode     = 1'b0;
         session_armed = 1'b0;
         errors        = 0;
      endfunction

      function void write_register(logic [mpem_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                   logic [mpem_pkg::CSR_DATA_WIDTH-1:0] value);
         case (idx)
            mpem_pkg::REG_PATTERN_A, mpem_pkg::REG_PATTERN_B,
            mpem_pkg::REG_PATTERN_C, mpem_pkg::REG_PATTERN_D: begin
               patterns[idx[1:0]] = value;
            end
            mpem_pkg::REG_LENGTHS:   lengths   = value[mpem_pkg::LENGTHS_WIDTH-1:0];
            mpem_pkg::REG_COUNT:     count     = value[mpem_pkg::COUNT_WIDTH-1:0];
            mpem_pkg::REG_TEXT_MODE: text_mode = value[0];
            default: ;
         endcase
      endfunction

      // Step the model on one accepted request and queue the response it owes.
      function void note_request(mpem_pkg::cmd_type cmd, logic [7:0] rx);
         mpem_pkg::result_type   outcome;
         int                     used;
         int                     limit;
         mpem_pkg::progress_type p;
         bit                     found;
         outcome.status      = mpem_pkg::STATUS_IDLE;
         outcome.match_index = '0;
         used  = (count > mpem_pkg::MAX_PATTERNS) ? mpem_pkg::MAX_PATTERNS : count;
         found = 1'b0;
         if (cmd == mpem_pkg::CMD_START) begin
            foreach (progress[i]) progress[i] = '0;
            session_armed = 1'b1;
         end else if (session_armed) begin
            outcome.status = mpem_pkg::STATUS_SEARCH;
            if (text_mode && rx == mpem_pkg::ZERO_BYTE) begin
               for (int i = 0; i < used; i++) progress[i] = '0;
            end else begin
               for (int i = 0; i < used && !found; i++) begin
                  p = progress[i];
                  // naive restart: a mismatching byte is not retried at position zero
                  if (p < mpem_pkg::MAX_PATTERN_LEN && patterns[i][8*p +: 8] == rx)
                     p = p + 1'b1;
                  else p = '0;
                  progress[i] = p;
                  limit = lengths[mpem_pkg::LEN_WIDTH*i +: mpem_pkg::LEN_WIDTH];
                  if (limit > mpem_pkg::MAX_PATTERN_LEN) limit = mpem_pkg::MAX_PATTERN_LEN;
                  if (p >= limit) begin
                     session_armed       = 1'b0;
                     outcome.status      = mpem_pkg::STATUS_MATCH;
                     outcome.match_index = mpem_pkg::MATCH_INDEX_WIDTH'(i);
                     found               = 1'b1;
                  end
               end
            end
         end
         awaited.push_back(outcome);
      endfunction

      function void check_response(logic [1:0] status,
                                   logic [mpem_pkg::MATCH_INDEX_WIDTH-1:0] index);
         mpem_pkg::result_type want;
         if (awaited.size() == 0) begin
            $error("unexpected response: status %0d match_index %0d", status, index);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index, index);
            errors++;
         end
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_command = mpem_pkg::CMD_START;
   logic [7:0]                             req_rx_byte = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [1:0]                             rsp_status;
   logic [mpem_pkg::MATCH_INDEX_WIDTH-1:0] rsp_match_index;
   logic                                   csr_write = 1'b0;
   logic [mpem_pkg::CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [mpem_pkg::CSR_DATA_WIDTH-1:0]    csr_data = '0;

   match_scoreboard sb = new();

   // per-cycle idle odds in percent, set per phase by the main sequence
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   // long receiver hold-off requested by the main sequence, in cycles
   int stall_burst       = 0;
   int cycle_count       = 0;
   // byte alphabet of the current random setup; noise draws from it too
   logic [7:0] letters [4];

   multi_pattern_expect_matcher_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   // Watchdog: a hang or a lost response ends the run here.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Receiver: checks each accepted response, then picks the next stall value.
   // A requested hold-off is counted down here while the sender keeps pushing.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) sb.check_response(rsp_status, rsp_match_index);
            if (hold_left == 0 && stall_burst > 0) begin
               hold_left   = stall_burst;
               stall_burst = 0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
         end
      end
   end

   // One register write; the model follows at the same edge.
   task automatic write_reg(logic [mpem_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [mpem_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.write_register(idx, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request, with random idle cycles first; returns once accepted.
   // Valid stays high afterwards so back-to-back requests need no extra edge.
   task automatic send(mpem_pkg::cmd_type cmd, logic [7:0] rx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, rx);
   endtask

   // Stop offering, wait for every owed response, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // New random setup: patterns over a small alphabet so partial matches are
   // common, mostly short lengths with the odd zero or one of eight or more.
   task automatic load_random_setup();
      logic [mpem_pkg::PATTERN_WIDTH-1:0] pat;
      logic [mpem_pkg::LENGTHS_WIDTH-1:0] lens;
      int                                 pick;
      for (int k = 0; k < 4; k++)
         letters[k] = ($urandom_range(7) == 0) ? mpem_pkg::ZERO_BYTE
                                               : 8'($urandom_range(255));
      for (int i = 0; i < mpem_pkg::MAX_PATTERNS; i++) begin
         for (int b = 0; b < mpem_pkg::PATTERN_BYTES; b++)
            pat[8*b +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                     : letters[$urandom_range(3)];
         write_reg(mpem_pkg::csr_index_type'(mpem_pkg::REG_PATTERN_A + i), pat);
         pick = $urandom_range(9);
         if (pick == 0)
            lens[mpem_pkg::LEN_WIDTH*i +: mpem_pkg::LEN_WIDTH] = '0;
         else if (pick == 1)
            lens[mpem_pkg::LEN_WIDTH*i +: mpem_pkg::LEN_WIDTH] = 4'($urandom_range(15, 8));
         else
            lens[mpem_pkg::LEN_WIDTH*i +: mpem_pkg::LEN_WIDTH] = 4'($urandom_range(5, 1));
      end
      write_reg(mpem_pkg::REG_LENGTHS, mpem_pkg::CSR_DATA_WIDTH'(lens));
      write_reg(mpem_pkg::REG_COUNT,
                ($urandom_range(5) == 0) ? mpem_pkg::CSR_DATA_WIDTH'($urandom_range(7))
                                         : mpem_pkg::CSR_DATA_WIDTH'($urandom_range(4, 2)));
      write_reg(mpem_pkg::REG_TEXT_MODE, mpem_pkg::CSR_DATA_WIDTH'($urandom_range(1)));
   endtask

   function automatic logic [7:0] noise_byte();
      int pick;
      pick = $urandom_range(19);
      if (pick < 10) return letters[$urandom_range(3)];
      if (pick < 17) return 8'($urandom_range(255));
      return mpem_pkg::ZERO_BYTE;
   endfunction

   // Random traffic: mostly a start followed by one pattern's bytes (sometimes
   // corrupted or cut short), then a little noise. Bytes sent while no session
   // is armed are ignored by the block and do not count toward the budget.
   task automatic run_random(int budget);
      int         done;
      int         sel;
      int         span;
      logic [7:0] b;
      done = 0;
      while (done < budget) begin
         if ($urandom_range(9) != 0) begin
            send(mpem_pkg::CMD_START, 8'($urandom_range(255)));
            done++;
         end
         sel  = $urandom_range(mpem_pkg::MAX_PATTERNS - 1);
         span = sb.lengths[mpem_pkg::LEN_WIDTH*sel +: mpem_pkg::LEN_WIDTH];
         if (span > mpem_pkg::MAX_PATTERN_LEN) span = mpem_pkg::MAX_PATTERN_LEN;
         if ($urandom_range(4) == 0) span = $urandom_range(span);
         for (int k = 0; k < span; k++) begin
            b = ($urandom_range(11) == 0) ? noise_byte() : sb.patterns[sel][8*k +: 8];
            if (sb.session_armed) done++;
            send(mpem_pkg::CMD_BYTE, b);
         end
         repeat ($urandom_range(3)) begin
            if (sb.session_armed) done++;
            send(mpem_pkg::CMD_BYTE, noise_byte());
         end
      end
      drain();
   endtask

   initial begin : main
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A = "OK" (len 2), B = FF then 00 (len 2), C = all FF
      // with an oversize length (acts as 8), D = 5A (len 1); count 7 acts as 4.
      write_reg(mpem_pkg::REG_PATTERN_A, 64'h0000_0000_0000_4B4F);
      write_reg(mpem_pkg::REG_PATTERN_B, 64'h0000_0000_0000_00FF);
      write_reg(mpem_pkg::REG_PATTERN_C, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(mpem_pkg::REG_PATTERN_D, 64'h0000_0000_0000_005A);
      write_reg(mpem_pkg::REG_LENGTHS, 64'h1F22);
      write_reg(mpem_pkg::REG_COUNT, 64'd7);
      write_reg(mpem_pkg::REG_TEXT_MODE, 64'd0);
      write_reg(REG_UNUSED, '1);
      send(mpem_pkg::CMD_BYTE, 8'h4F);             // no session yet: ignored
      send(mpem_pkg::CMD_START, 8'hFF);
      send(mpem_pkg::CMD_BYTE, 8'h4F);
      send(mpem_pkg::CMD_BYTE, 8'h4B);             // pattern A completes
      send(mpem_pkg::CMD_BYTE, 8'h5A);             // session closed by the match: ignored
      send(mpem_pkg::CMD_START, 8'h00);
      send(mpem_pkg::CMD_BYTE, 8'hFF);
      send(mpem_pkg::CMD_BYTE, mpem_pkg::ZERO_BYTE); // zero byte matches B outside text mode
      send(mpem_pkg::CMD_START, 8'h00);
      send(mpem_pkg::CMD_BYTE, 8'h5A);             // D wins when the earlier ones miss
      send(mpem_pkg::CMD_START, 8'h00);
      repeat (8) send(mpem_pkg::CMD_BYTE, 8'hFF);  // C runs to the full length
      drain();

      // Text mode: a zero byte clears the progress of every pattern in use and never completes.
      write_reg(mpem_pkg::REG_TEXT_MODE, 64'd1);
      send(mpem_pkg::CMD_START, 8'h00);
      send(mpem_pkg::CMD_BYTE, 8'h4F);
      send(mpem_pkg::CMD_BYTE, mpem_pkg::ZERO_BYTE);
      send(mpem_pkg::CMD_BYTE, 8'h4B);
      send(mpem_pkg::CMD_BYTE, 8'h4F);
      drain();
      // A's length drops under its progress mid-session
      write_reg(mpem_pkg::REG_LENGTHS, 64'h1F20);
      send(mpem_pkg::CMD_BYTE, 8'h11);
      // A now has length zero: completes on anything but a zero byte
      send(mpem_pkg::CMD_START, 8'h00);
      send(mpem_pkg::CMD_BYTE, mpem_pkg::ZERO_BYTE);
      send(mpem_pkg::CMD_BYTE, 8'h33);
      drain();
      // no patterns in use: searching forever
      write_reg(mpem_pkg::REG_COUNT, 64'd0);
      send(mpem_pkg::CMD_START, 8'h00);
      send(mpem_pkg::CMD_BYTE, 8'h4F);
      drain();

      // Random phases: sender gaps light / receiver heavy, then swapped,
      // then none at all with one long receiver hold-off to back up the pipe.
      sender_idle_pct   = 24;
      receiver_idle_pct = 46;
      repeat (2) begin
         load_random_setup();
         run_random(67);
      end
      sender_idle_pct   = 46;
      receiver_idle_pct = 24;
      repeat (2) begin
         load_random_setup();
         run_random(67);
      end
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      load_random_setup();
      stall_burst = 80;
      run_random(67);
      load_random_setup();
      run_random(67);

      // drain() already waited out the tail; anything late is flagged too
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
